// ===== rtl/core/lpa_pkg.sv =====
// Shared types and constants for the lease pool allocator.
`default_nettype none

package lpa_pkg;

  // Field widths
  localparam int OP_W     = 2;
  localparam int ENTRY_W  = 5;
  localparam int TIME_W   = 32;
  localparam int STATUS_W = 3;
  localparam int LINK_W   = 6;

  // Used-list link that points nowhere
  localparam logic [LINK_W-1:0] NULL_LINK = 6'd63;

  // Lease timeout after reset, in milliseconds
  localparam logic [TIME_W-1:0] DEFAULT_TIMEOUT_MS = 32'd60000;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_RECLAIMED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REJECTED  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_QUERY     = 3'd5;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_GRANT,
    S_REL,
    S_QUERY,
    S_WALK_RD,
    S_WALK_EV,
    S_WALK_END
  } lpa_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture the accepted transaction
    logic walk_init;  // start the timeout walk at the newest lease
    logic rd_node;    // read link and time stores at the walk node
    logic walk_step;  // move the walk to the next older lease
    logic reclaim;    // reclaim the walk node and emit its result
    logic grant;      // pop the free stack and emit the grant
    logic rel;        // release the requested entry and emit the answer
    logic query;      // emit the query answer
    logic exhaust;    // emit the exhausted result
  } lpa_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic fc_zero;    // free stack is empty
    logic node_go;    // walk node is valid and the guard is not spent
    logic expired;    // lease at the walk node is past the timeout
    logic out_free;   // output register can take a result this cycle
  } lpa_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/lpa_if.sv =====
// Request and response channel interfaces of the lease pool allocator.
`default_nettype none

interface lpa_req_if;
  logic                         valid;
  logic                         ready;
  logic [lpa_pkg::OP_W-1:0]     operation;
  logic [lpa_pkg::ENTRY_W-1:0]  entry;
  logic [lpa_pkg::TIME_W-1:0]   now;

  modport source (output valid, output operation, output entry, output now, input ready);
  modport sink   (input valid, input operation, input entry, input now, output ready);
endinterface

interface lpa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [lpa_pkg::STATUS_W-1:0]  status;
  logic [lpa_pkg::ENTRY_W-1:0]   entry_id;
  logic                          in_use;
  logic                          last;

  modport source (output valid, output status, output entry_id, output in_use, output last,
                  input ready);
  modport sink   (input valid, input status, input entry_id, input in_use, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lpa_ctrl.sv =====
// Controller state machine of the lease pool allocator.
`default_nettype none

module lpa_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     req_valid,
  input  wire logic [lpa_pkg::OP_W-1:0] req_op,
  output logic                          req_ready,
  input  wire lpa_pkg::lpa_sts_t        sts,
  output lpa_pkg::lpa_cmd_t             cmd
);
  import lpa_pkg::*;

  lpa_state_t state;
  lpa_state_t state_next;

  // Hold the state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Advance the state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          unique case (req_op)
            OP_ALLOC:   state_next = sts.fc_zero ? S_WALK_RD : S_GRANT;
            OP_RELEASE: state_next = S_REL;
            OP_QUERY:   state_next = S_QUERY;
            default:    state_next = S_IDLE;
          endcase
        end
      end
      S_GRANT, S_REL, S_QUERY: begin
        if (sts.out_free) state_next = S_IDLE;
      end
      S_WALK_RD: begin
        state_next = sts.node_go ? S_WALK_EV : S_WALK_END;
      end
      S_WALK_EV: begin
        if (!sts.expired || sts.out_free) state_next = S_WALK_RD;
      end
      S_WALK_END: begin
        if (!sts.fc_zero) begin
          state_next = S_GRANT;
        end else if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Drive commands for the datapath
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready     = 1'b1;
        cmd.load      = req_valid;
        cmd.walk_init = req_valid && (req_op == OP_ALLOC) && sts.fc_zero;
      end
      S_GRANT: cmd.grant   = sts.out_free;
      S_REL:   cmd.rel     = sts.out_free;
      S_QUERY: cmd.query   = sts.out_free;
      S_WALK_RD: begin
        cmd.rd_node = 1'b1;
      end
      S_WALK_EV: begin
        cmd.rd_node   = 1'b1;
        cmd.walk_step = !sts.expired || sts.out_free;
        cmd.reclaim   = sts.expired && sts.out_free;
      end
      S_WALK_END: cmd.exhaust = sts.fc_zero && sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lpa_dp.sv =====
// Datapath of the lease pool allocator: stores, free stack, used list, result register.
`default_nettype none

module lpa_dp #(
  parameter int POOL_SIZE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [lpa_pkg::TIME_W-1:0]  cfg_wdata,
  input  wire logic [lpa_pkg::ENTRY_W-1:0] entry_in,
  input  wire logic [lpa_pkg::TIME_W-1:0]  now_in,
  input  wire lpa_pkg::lpa_cmd_t           cmd,
  output lpa_pkg::lpa_sts_t                sts,
  lpa_rsp_if.source                        rsp
);
  import lpa_pkg::*;

  localparam int IDX_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W = $clog2(POOL_SIZE + 1);
  localparam logic [LINK_W-1:0] POOL_LINK = LINK_W'(POOL_SIZE);
  localparam logic [CNT_W-1:0]  POOL_CNT  = CNT_W'(POOL_SIZE);

  // Control and transaction registers
  logic [TIME_W-1:0]    timeout;
  logic [ENTRY_W-1:0]   entry_q;
  logic [TIME_W-1:0]    now_q;
  logic [CNT_W-1:0]     fc;
  logic [LINK_W-1:0]    newest;
  logic [LINK_W-1:0]    node;
  logic [CNT_W-1:0]     guard;
  logic [POOL_SIZE-1:0] leased;
  logic [POOL_SIZE-1:0] stk_wr;

  // Stores
  logic [IDX_W-1:0]  stk_mem [POOL_SIZE];
  logic [LINK_W-1:0] prv_mem [POOL_SIZE];
  logic [LINK_W-1:0] nxt_mem [POOL_SIZE];
  logic [TIME_W-1:0] gt_mem  [POOL_SIZE];

  // Registered read data
  logic [IDX_W-1:0]  stk_rd;
  logic [LINK_W-1:0] prv_rd;
  logic [LINK_W-1:0] nxt_rd;
  logic [TIME_W-1:0] gt_rd;

  // Output register
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [ENTRY_W-1:0]  out_id;
  logic                out_in_use;
  logic                out_last;

  logic [LINK_W-1:0] entry_ext;
  logic              e_ok;
  logic [IDX_W-1:0]  e_idx;
  logic              e_leased;
  logic [LINK_W-1:0] rd_link;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  node_idx;
  logic [CNT_W-1:0]  fc_m1;
  logic [IDX_W-1:0]  stk_addr;
  logic [IDX_W-1:0]  push_idx;
  logic              do_unlink;
  logic              do_push;
  logic [LINK_W-1:0] ul_e;
  logic [LINK_W-1:0] ul_p;
  logic [LINK_W-1:0] ul_n;
  logic              p_ok;
  logic              n_ok;
  logic              newest_ok;
  logic [LINK_W-1:0] g_link;
  logic [TIME_W-1:0] age;
  logic              emit;
  logic              out_free;

  // Decode the requested entry and the walk node
  assign entry_ext = LINK_W'(entry_q);
  assign e_ok      = entry_ext < POOL_LINK;
  assign e_idx     = entry_ext[IDX_W-1:0];
  assign e_leased  = e_ok && leased[e_idx];
  assign node_idx  = node[IDX_W-1:0];
  assign newest_ok = newest < POOL_LINK;
  assign g_link    = LINK_W'(stk_rd);

  // Select link read address: incoming entry, walk node or held entry
  assign rd_link = cmd.load ? LINK_W'(entry_in) : (cmd.rd_node ? node : entry_ext);
  assign rd_idx  = rd_link[IDX_W-1:0];

  // Free stack top and push slot
  assign fc_m1    = fc - 1'b1;
  assign stk_addr = fc_m1[IDX_W-1:0];
  assign push_idx = fc[IDX_W-1:0];

  // Unlink of a released or reclaimed entry
  assign do_unlink = cmd.reclaim || (cmd.rel && e_leased);
  assign do_push   = do_unlink && (fc < POOL_CNT);
  assign ul_e      = cmd.reclaim ? node : entry_ext;
  assign ul_p      = prv_rd;
  assign ul_n      = (ul_e == newest) ? NULL_LINK : nxt_rd;
  assign p_ok      = ul_p < POOL_LINK;
  assign n_ok      = ul_n < POOL_LINK;

  // Lease age, wrapping
  assign age = now_q - gt_rd;

  assign emit     = cmd.grant || cmd.reclaim || cmd.rel || cmd.query || cmd.exhaust;
  assign out_free = !out_valid || rsp.ready;

  assign sts.fc_zero  = (fc == '0);
  assign sts.node_go  = (node < POOL_LINK) && (guard < POOL_CNT);
  assign sts.expired  = age > timeout;
  assign sts.out_free = out_free;

  // Read stores
  always_ff @(posedge clk) begin
    stk_rd <= stk_wr[stk_addr] ? stk_mem[stk_addr] : stk_addr;
    prv_rd <= prv_mem[rd_idx];
    nxt_rd <= nxt_mem[rd_idx];
    gt_rd  <= gt_mem[node_idx];
  end

  // Write free stack
  always_ff @(posedge clk) begin
    if (do_push) begin
      stk_mem[push_idx] <= ul_e[IDX_W-1:0];
    end
  end

  // Write grant time
  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      gt_mem[stk_rd] <= now_q;
    end
  end

  // Write older-neighbor links
  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      prv_mem[stk_rd] <= newest;
    end else if (do_unlink && n_ok) begin
      prv_mem[ul_n[IDX_W-1:0]] <= ul_p;
    end
  end

  // Write newer-neighbor links
  always_ff @(posedge clk) begin
    if (cmd.grant && newest_ok) begin
      nxt_mem[newest[IDX_W-1:0]] <= g_link;
    end else if (do_unlink && p_ok) begin
      nxt_mem[ul_p[IDX_W-1:0]] <= ul_n;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      entry_q <= entry_in;
      now_q   <= now_in;
    end
  end

  // Update pool control state
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= DEFAULT_TIMEOUT_MS;
      fc      <= POOL_CNT;
      newest  <= NULL_LINK;
      node    <= NULL_LINK;
      guard   <= '0;
      leased  <= '0;
      stk_wr  <= '0;
    end else begin
      if (cfg_we) timeout <= cfg_wdata;

      if (cmd.grant) begin
        fc             <= fc_m1;
        newest         <= g_link;
        leased[stk_rd] <= 1'b1;
      end else begin
        if (do_unlink) begin
          leased[ul_e[IDX_W-1:0]] <= 1'b0;
          if (!n_ok) newest <= ul_p;
        end
        if (do_push) begin
          fc               <= fc + 1'b1;
          stk_wr[push_idx] <= 1'b1;
        end
      end

      if (cmd.walk_init) begin
        node  <= newest;
        guard <= '0;
      end else if (cmd.walk_step) begin
        node  <= prv_rd;
        guard <= guard + 1'b1;
      end
    end
  end

  // Hold the result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (cmd.grant) begin
      out_status <= ST_GRANTED;
      out_id     <= ENTRY_W'(g_link);
      out_in_use <= 1'b0;
      out_last   <= 1'b1;
    end else if (cmd.reclaim) begin
      out_status <= ST_RECLAIMED;
      out_id     <= ENTRY_W'(node);
      out_in_use <= 1'b0;
      out_last   <= 1'b0;
    end else if (cmd.rel) begin
      out_status <= e_leased ? ST_RELEASED : ST_REJECTED;
      out_id     <= entry_q;
      out_in_use <= 1'b0;
      out_last   <= 1'b1;
    end else if (cmd.query) begin
      out_status <= ST_QUERY;
      out_id     <= entry_q;
      out_in_use <= e_leased;
      out_last   <= 1'b1;
    end else if (cmd.exhaust) begin
      out_status <= ST_EXHAUSTED;
      out_id     <= '0;
      out_in_use <= 1'b0;
      out_last   <= 1'b1;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_status;
  assign rsp.entry_id = out_id;
  assign rsp.in_use   = out_in_use;
  assign rsp.last     = out_last;

endmodule

`default_nettype wire

// ===== rtl/core/lease_pool_allocator_timeout_core.sv =====
// Allocate, release and query load their result from the grant, release or query state;
// a stalled result register holds the controller until taken.
// An allocate on an empty pool walks the used list through a read state and an evaluate
// state per lease, then loads the exhausted result at walk end or the grant in S_GRANT.
// Timing is set by one registered store read per step of the controller.
// Synchronous reset: full free stack, empty used list, timeout 60000 ms.
`default_nettype none

module lease_pool_allocator_timeout_core #(
  parameter int POOL_SIZE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [lpa_pkg::TIME_W-1:0]  cfg_wdata,
  lpa_req_if.sink                          req,
  lpa_rsp_if.source                        rsp
);
  import lpa_pkg::*;

  lpa_cmd_t cmd;
  lpa_sts_t sts;
  logic     emit;

  // Sequence each transaction
  lpa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_op    (req.operation),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold pool state and results
  lpa_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .entry_in  (req.entry),
    .now_in    (req.now),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

  assign emit = cmd.grant || cmd.reclaim || cmd.rel || cmd.query || cmd.exhaust;

  // At most one result is produced per cycle
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.grant, cmd.reclaim, cmd.rel, cmd.query, cmd.exhaust}))
    else $error("more than one result command in a cycle");

  // A result is only loaded when the output register can take it
  assert property (@(posedge clk) disable iff (rst) emit |-> sts.out_free)
    else $error("result loaded into a busy output register");

  // No result is produced in the cycle a transaction is accepted
  assert property (@(posedge clk) disable iff (rst) (req.valid && req.ready) |-> !emit)
    else $error("result emitted while accepting a transaction");

  // A grant ends the transaction
  assert property (@(posedge clk) disable iff (rst) cmd.grant |=> req.ready)
    else $error("not ready after a grant");

endmodule

`default_nettype wire
